### rtl/itl_pkg.sv
package itl_pkg;

   localparam int ENTRIES  = 4096;
   localparam int POS_BITS = 48;
   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int SLOT_W   = 12;
   localparam int COUNT_W  = 13;
   localparam int HDR_W    = 32;
   localparam int OFS_W    = POS_BITS + 1;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_LOOKUP = 1'b1
   } command_type;

   typedef struct packed {
      logic                command;
      logic [SLOT_W-1:0]   entry_slot;
      logic [POS_BITS-1:0] interval_begin;
      logic [POS_BITS-1:0] interval_end;
      logic [HDR_W-1:0]    header_start;
      logic [POS_BITS-1:0] query_pos;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   entry_found;
      logic [OFS_W-1:0]    offset_in_interval;
      logic [HDR_W-1:0]    header_offset;
      logic [POS_BITS-1:0] query_echo;
   } rsp_type;

   typedef struct packed {
      logic [POS_BITS-1:0] lo_pos;
      logic [POS_BITS-1:0] hi_pos;
      logic [HDR_W-1:0]    header;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      entry_type           data;
   } store_wr_type;

endpackage

### rtl/itl_store.sv
module itl_store import itl_pkg::*; (
   input  logic                clock,
   input  store_wr_type        wr,
   input  logic                rd_en,
   input  logic [IDX_BITS-1:0] rd_addr,
   output entry_type           rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/interval_table_lookup_top.sv
// Load request: written to the table on accept, busy stays low, no response.
// Lookup request: raises busy until the response strobe, taking at most
// ceil(log2(entry_count+1)) probes (13 for a full 4096-entry table).
// No new request is accepted while busy: one probe per cycle through the single read port.
// Synchronous reset clears entry_count and control; table contents stay undefined.
// Responses cannot be stalled by the receiver.
module interval_table_lookup_top import itl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FIRST = 3'b010,
      ST_PROBE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0] left_ff, left_in;
   logic [CNT_BITS-1:0] right_ff, right_in;
   logic [CNT_BITS-1:0] mid_ff, mid_in;
   logic [POS_BITS-1:0] query_ff, query_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   store_wr_type        wr;
   logic                rd_en;
   logic [IDX_BITS-1:0] rd_addr;
   entry_type           rd_data;

   logic                accept;
   logic [CNT_BITS-1:0] count_clamp;
   logic [CNT_BITS:0]   sum_first, sum_r, sum_l;
   logic [CNT_BITS-1:0] mid_first, mid_r, mid_l, mid_plus;
   logic                more_r, more_l;
   logic                go_right, go_left, hit;

   itl_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign count_in = csr_valid ? csr_data : count_ff;

   always_comb begin
      wr.en          = accept && (req_data.command == CMD_LOAD) &&
                       (32'(req_data.entry_slot) < 32'(ENTRIES));
      wr.addr        = IDX_BITS'(req_data.entry_slot);
      wr.data.lo_pos = req_data.interval_begin;
      wr.data.hi_pos = req_data.interval_end;
      wr.data.header = req_data.header_start;
   end

   always_comb begin
      count_clamp = (32'(count_ff) > 32'(ENTRIES)) ? CNT_BITS'(ENTRIES)
                                                   : CNT_BITS'(count_ff);
      sum_first   = {1'b0, left_ff} + {1'b0, right_ff};
      mid_first   = sum_first[CNT_BITS:1];
      mid_plus    = mid_ff + CNT_BITS'(1);
      sum_r       = {1'b0, mid_plus} + {1'b0, right_ff};
      mid_r       = sum_r[CNT_BITS:1];
      more_r      = mid_plus < right_ff;
      sum_l       = {1'b0, left_ff} + {1'b0, mid_ff};
      mid_l       = sum_l[CNT_BITS:1];
      more_l      = left_ff < mid_ff;
      go_right    = rd_data.hi_pos <= query_ff;
      go_left     = query_ff < rd_data.lo_pos;
      hit         = !go_right && !go_left;
   end

   always_comb begin
      state_in      = state_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      query_in      = query_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = IDX_BITS'(mid_first);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.command == CMD_LOOKUP)) begin
               left_in  = '0;
               right_in = count_clamp;
               query_in = req_data.query_pos;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (left_ff < right_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IDX_BITS'(mid_first);
               mid_in   = mid_first;
               state_in = ST_PROBE;
            end else begin
               rsp_in            = '0;
               rsp_in.query_echo = query_ff;
               rsp_strobe_in     = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_PROBE: begin
            if (hit) begin
               rsp_in.found              = 1'b1;
               rsp_in.entry_found        = SLOT_W'(mid_ff);
               rsp_in.offset_in_interval = {1'b0, query_ff} - {1'b0, rd_data.lo_pos}
                                           + OFS_W'(1);
               rsp_in.header_offset      = rd_data.header;
               rsp_in.query_echo         = query_ff;
               rsp_strobe_in             = 1'b1;
               state_in                  = ST_IDLE;
            end else if (go_right) begin
               left_in = mid_plus;
               if (more_r) begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_BITS'(mid_r);
                  mid_in  = mid_r;
               end else begin
                  rsp_in            = '0;
                  rsp_in.query_echo = query_ff;
                  rsp_strobe_in     = 1'b1;
                  state_in          = ST_IDLE;
               end
            end else begin
               right_in = mid_ff;
               if (more_l) begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_BITS'(mid_l);
                  mid_in  = mid_l;
               end else begin
                  rsp_in            = '0;
                  rsp_in.query_echo = query_ff;
                  rsp_strobe_in     = 1'b1;
                  state_in          = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      mid_ff   <= mid_in;
      query_ff <= query_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### rtl/itl_checker.sv
module itl_checker import itl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe on consecutive cycles");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.command == CMD_LOOKUP)) |=> busy)
      else $error("lookup request did not raise busy");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.command == CMD_LOAD)) |=> !busy && !rsp_strobe)
      else $error("load request raised busy or a response");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while still busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |->
         (rsp_data.entry_found == '0) && (rsp_data.offset_in_interval == '0) &&
         (rsp_data.header_offset == '0))
      else $error("miss response carries nonzero fields");

endmodule

bind interval_table_lookup_top itl_checker u_itl_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import itl_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS = 1680;
   localparam logic [POS_BITS-1:0] TOP_POS = '1;
   localparam int COUNT_TOP = (1 << COUNT_W) - 1;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   logic [POS_BITS-1:0] span_lo [ENTRIES];
   logic [POS_BITS-1:0] span_hi [ENTRIES];
   logic [HDR_W-1:0]    span_hdr [ENTRIES];
   int                  search_count;
   int                  spine_slots[$];

   rsp_type lookup_answers[$];
   rsp_type answer_due;
   int      failures;
   int      quiet_cycles;
   int      sent_items;
   bit      steady_flow;

   interval_table_lookup_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [POS_BITS-1:0] random_pos();
      logic [63:0] v;
      v = wide_random();
      return v[POS_BITS-1:0];
   endfunction

   function automatic rsp_type locate_position(input logic [POS_BITS-1:0] q);
      rsp_type r;
      int      lo_i;
      int      hi_i;
      int      mid;
      r = '0;
      r.query_echo = q;
      lo_i = 0;
      hi_i = (search_count > ENTRIES) ? ENTRIES : search_count;
      while (lo_i < hi_i) begin
         mid = (lo_i + hi_i) / 2;
         if (span_hi[mid] <= q) begin
            lo_i = mid + 1;
         end else if (q < span_lo[mid]) begin
            hi_i = mid;
         end else begin
            r.found = 1'b1;
            r.entry_found = mid[SLOT_W-1:0];
            r.offset_in_interval = {1'b0, q - span_lo[mid]} + 1;
            r.header_offset = span_hdr[mid];
            break;
         end
      end
      return r;
   endfunction

   function automatic req_type load_item(input logic [SLOT_W-1:0] slot,
                                         input logic [POS_BITS-1:0] lo,
                                         input logic [POS_BITS-1:0] hi,
                                         input logic [HDR_W-1:0] hdr);
      req_type r;
      r.command = CMD_LOAD;
      r.entry_slot = slot;
      r.interval_begin = lo;
      r.interval_end = hi;
      r.header_start = hdr;
      r.query_pos = random_pos();
      return r;
   endfunction

   function automatic req_type lookup_item(input logic [POS_BITS-1:0] q);
      req_type r;
      r.command = CMD_LOOKUP;
      r.entry_slot = SLOT_W'($urandom);
      r.interval_begin = random_pos();
      r.interval_end = random_pos();
      r.header_start = $urandom;
      r.query_pos = q;
      return r;
   endfunction

   function automatic logic [POS_BITS-1:0] pick_query(input int n);
      int                  k;
      logic [POS_BITS-1:0] lo;
      logic [POS_BITS-1:0] hi;
      if (n == 0 || $urandom_range(9) < 2) return random_pos();
      k = $urandom_range(n - 1);
      lo = span_lo[k];
      hi = span_hi[k];
      case ($urandom_range(5))
         0: return lo;
         1: return hi - 1;
         2: return hi;
         3: return lo - 1;
         default: begin
            if (hi > lo) return lo + random_pos() % (hi - lo);
            return lo;
         end
      endcase
   endfunction

   function automatic logic [POS_BITS-1:0] spine_query();
      int                  k;
      logic [POS_BITS-1:0] lo;
      logic [POS_BITS-1:0] hi;
      case ($urandom_range(7))
         0: return '0;
         1: return TOP_POS;
         default: begin
            k = spine_slots[$urandom_range(spine_slots.size() - 1)];
            lo = span_lo[k];
            hi = span_hi[k];
            return lo + random_pos() % (hi - lo);
         end
      endcase
   endfunction

   function automatic int gap_cycles();
      if (!steady_flow && $urandom_range(99) < 23) return $urandom_range(1, 4);
      return 0;
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      gap = gap_cycles();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (item.command == CMD_LOAD) begin
         span_lo[item.entry_slot] = item.interval_begin;
         span_hi[item.entry_slot] = item.interval_end;
         span_hdr[item.entry_slot] = item.header_start;
      end else begin
         lookup_answers.push_back(locate_position(item.query_pos));
      end
      sent_items++;
   endtask

   task automatic settle_block();
      @(negedge clock);
      start <= 1'b0;
      while (lookup_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input int value);
      @(negedge clock);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_data <= value[COUNT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      search_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_sorted(input int n);
      logic [63:0] stride;
      logic [63:0] lo;
      logic [63:0] len;
      logic [63:0] hi;
      stride = (64'd1 << POS_BITS) / n;
      for (int k = 0; k < n; k++) begin
         lo = k * stride + wide_random() % (stride / 2);
         len = ($urandom_range(3) == 0) ? 64'($urandom_range(15))
                                        : wide_random() % (stride / 2);
         hi = lo + len;
         send_request(load_item(k[SLOT_W-1:0], lo[POS_BITS-1:0], hi[POS_BITS-1:0],
                                $urandom));
      end
   endtask

   // load only the entries on the all-left and all-right search paths of a full table
   task automatic load_spine();
      logic [63:0] stride;
      logic [63:0] lo;
      logic [63:0] hi;
      int          lo_i;
      int          hi_i;
      int          mid;
      stride = (64'd1 << POS_BITS) / ENTRIES;
      spine_slots.delete();
      for (int side = 0; side < 2; side++) begin
         lo_i = 0;
         hi_i = ENTRIES;
         while (lo_i < hi_i) begin
            mid = (lo_i + hi_i) / 2;
            lo = 64'(mid) * stride + 1 + wide_random() % (stride / 2);
            hi = lo + 1 + wide_random() % (stride / 4);
            send_request(load_item(mid[SLOT_W-1:0], lo[POS_BITS-1:0], hi[POS_BITS-1:0],
                                   $urandom));
            spine_slots.push_back(mid);
            if (side == 0) hi_i = mid;
            else lo_i = mid + 1;
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      failures++;
      if (failures <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
   endtask

   task automatic test_reset_state();
      send_request(lookup_item('0));
      send_request(lookup_item(TOP_POS));
      settle_block();
      write_count(0);
      send_request(lookup_item(random_pos()));
   endtask

   task automatic test_directed();
      logic [POS_BITS-1:0] half;
      logic [POS_BITS-1:0] probes [12];
      half = {1'b1, {(POS_BITS-1){1'b0}}};
      send_request(load_item(0, 0, 10, 0));
      send_request(load_item(1, 10, 10, '1));
      send_request(load_item(2, 20, 15, 5));
      send_request(load_item(3, 100, 200, 32'h8000_0001));
      send_request(load_item(4, 1000, 1001, 7));
      send_request(load_item(5, half, TOP_POS, '1));
      settle_block();
      write_count(6);
      probes = '{0, 9, 10, 17, 100, 199, 200, 1000, 1001, half, TOP_POS - 1, TOP_POS};
      foreach (probes[i]) send_request(lookup_item(probes[i]));
      // break the sort order of the table
      send_request(load_item(3, 5000, 6000, 3));
      send_request(lookup_item(5500));
      send_request(lookup_item(150));
   endtask

   task automatic test_count_clamp();
      settle_block();
      load_spine();
      write_count(ENTRIES);
      repeat (40) send_request(lookup_item(spine_query()));
      settle_block();
      write_count($urandom_range(ENTRIES + 1, COUNT_TOP));
      repeat (40) send_request(lookup_item(spine_query()));
      settle_block();
      write_count(COUNT_TOP);
      repeat (40) send_request(lookup_item(spine_query()));
   endtask

   task automatic test_random();
      int first_item;
      int n;
      int k;
      bit reload;
      first_item = sent_items;
      while (sent_items - first_item < RANDOM_ITEMS) begin
         steady_flow = (sent_items - first_item >= 600) && (sent_items - first_item < 950);
         settle_block();
         reload = 1'b1;
         case ($urandom_range(9))
            0: n = 1;
            1: n = 2;
            2: begin
               n = 0;
               reload = 1'b0;
            end
            default: n = $urandom_range(3, 48);
         endcase
         if (reload) load_sorted(n);
         write_count(n);
         repeat ($urandom_range(30, 90)) begin
            k = $urandom_range(99);
            if (k < 8) begin
               send_request(load_item(SLOT_W'($urandom), random_pos(), random_pos(),
                                      $urandom));
            end else if (k < 10) begin
               settle_block();
            end else begin
               send_request(lookup_item(pick_query((n > ENTRIES) ? ENTRIES : n)));
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (lookup_answers.size() == 0) begin
            flag_mismatch("unexpected result, query", '0, rsp_data.query_echo);
         end else begin
            answer_due = lookup_answers.pop_front();
            if (rsp_data.found !== answer_due.found)
               flag_mismatch("found", answer_due.found, rsp_data.found);
            if (rsp_data.entry_found !== answer_due.entry_found)
               flag_mismatch("entry_found", answer_due.entry_found, rsp_data.entry_found);
            if (rsp_data.offset_in_interval !== answer_due.offset_in_interval)
               flag_mismatch("offset_in_interval", answer_due.offset_in_interval,
                             rsp_data.offset_in_interval);
            if (rsp_data.header_offset !== answer_due.header_offset)
               flag_mismatch("header_offset", answer_due.header_offset,
                             rsp_data.header_offset);
            if (rsp_data.query_echo !== answer_due.query_echo)
               flag_mismatch("query_echo", answer_due.query_echo, rsp_data.query_echo);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      failures = 0;
      quiet_cycles = 0;
      sent_items = 0;
      steady_flow = 1'b0;
      search_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed();
      test_count_clamp();
      test_random();
      settle_block();
      if (lookup_answers.size() != 0) begin
         flag_mismatch("results never received", '0, lookup_answers.size());
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
